// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// File: sv/cfpr_pkg.sv
// Package with codes, field widths and the CRC-16 byte update of the receiver.
`timescale 1ns / 1ps

package cfpr_pkg;

   // Input action codes (carried in req_tuser)
   localparam logic ACT_RECEIVE = 1'b0;
   localparam logic ACT_READ    = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_IGNORED   = 2'd0;
   localparam logic [1:0] ST_ACCEPTED  = 2'd1;
   localparam logic [1:0] ST_COMMITTED = 2'd2;
   localparam logic [1:0] ST_REJECTED  = 2'd3;

   // Configuration register indexes
   localparam logic [7:0] CSR_EXPECTED_LEN = 8'd0;
   localparam logic [7:0] CSR_CRC_MODE     = 8'd1;

   // CRC modes
   localparam logic CRC_MSB_FIRST = 1'b0;
   localparam logic CRC_LSB_FIRST = 1'b1;

   // Framing constants
   localparam logic [7:0]  START_MARK   = 8'hAA;
   localparam logic [15:0] CRC_SEED     = 16'hFFFF;
   localparam logic [15:0] POLY_NORMAL  = 16'h1021;
   localparam logic [15:0] POLY_REFLECT = 16'h8408;
   localparam logic [7:0]  LENGTH_RESET = 8'd64;

   // Position counter width
   localparam int POS_W = 9;

   // Response payload width (27 bits of fields padded to whole bytes)
   localparam int RSP_DATA_W = 32;

   // One byte of CRC-16 CCITT, unrolled over eight bit steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                            input logic mode);
      logic [15:0] c;
      c = crc;
      if (mode == CRC_LSB_FIRST) begin
         c = c ^ {8'h00, b};
         for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ POLY_REFLECT) : (c >> 1);
         end
      end else begin
         c = c ^ {b, 8'h00};
         for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ POLY_NORMAL) : (c << 1);
         end
      end
      return c;
   endfunction

endpackage

// File: sv/crc_framed_packet_receiver.sv
// Top level of the CRC-16 framed packet receiver with double-buffered payload store.
`timescale 1ns / 1ps

// Usage:
//   req channel: one transaction per received link byte (req_tuser = 0) or per
//   read of a committed payload byte (req_tuser = 1). Frames are start byte
//   0xAA, length byte (must match the expected length register), payload,
//   then CRC-16 low byte and high byte.
//   rsp channel: exactly one transaction per req transaction, in order, with
//   status, read byte, committed CRC and frame-available flag.
//   csr channel: register writes, index 0 expected length, 1 crc_mode; always ready.
//   The user writes only while no transaction is in flight; the block does not enforce it.
//   Result path: the memory read and request fields register into the read stage at
//   the accept edge; the output register loads from them once the output stage is
//   free or draining, and holds the result on rsp until it is taken.
//   Throughput: one transaction per cycle while rsp_tready is high; frame state
//   updates and the bank write happen at the accept edge.
//   Stall: with rsp_tready low the output stage holds and one more request is
//   accepted into the read stage; then req_tready drops until rsp drains.
//   Reset: framing hunts for a start byte, no frame is available, registers
//   return to expected length 64 and crc_mode 0. Payload memory is not cleared.
module crc_framed_packet_receiver #(
   parameter int PAYLOAD_CAPACITY = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // rx_byte[7:0], read_index[15:8]
   input  logic                              req_tuser,  // action
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rx_status[1:0], read_data[9:2], committed_crc[25:10], frame_available[26], zero[31:27]
   output logic [cfpr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [7:0]                        csr_index,
   input  logic [7:0]                        csr_data
);

   localparam int MEM_DEPTH = 2 * PAYLOAD_CAPACITY;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int POS_W     = cfpr_pkg::POS_W;

   // Configuration registers
   logic [7:0] expected_len_ff;
   logic       crc_mode_ff;

   // Frame state
   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   logic [15:0]      running_crc_ff, running_crc_in;
   logic             committed_bank_ff, committed_bank_in;
   logic             have_frame_ff, have_frame_in;
   logic [15:0]      bank_crc_ff [2];

   // Payload memory
   logic [7:0]        payload_mem [MEM_DEPTH];
   logic [7:0]        mem_q_ff;
   logic              mem_wr_en;
   logic [MEM_AW-1:0] mem_wr_addr, mem_rd_addr;

   // Read stage
   logic        s1_valid_ff;
   logic [1:0]  s1_status_ff;
   logic [15:0] s1_crc_ff;
   logic        s1_avail_ff;
   logic        s1_rd_en_ff;

   // Output stage
   logic                            out_valid_ff;
   logic [cfpr_pkg::RSP_DATA_W-1:0] out_data_ff;

   // Decoded request
   logic        in_acc;
   logic [7:0]  rx_byte;
   logic [7:0]  read_index;
   logic [9:0]  pos_ext, crc_lo_pos;
   logic [9:0]  pay_off;
   logic [15:0] crc_upd;
   logic [1:0]  status_in;
   logic        commit;
   logic        rd_en_in;
   logic [15:0] crc_out_in;
   logic        s1_adv;

   assign rx_byte    = req_tdata[7:0];
   assign read_index = req_tdata[15:8];
   assign csr_ready  = 1'b1;

   // Handshake: read stage moves on when the output stage is free or draining
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign in_acc     = req_tvalid && req_tready;

   assign pos_ext    = {1'b0, byte_position_ff};
   assign crc_lo_pos = 10'd2 + {2'b00, expected_len_ff};
   assign pay_off    = pos_ext - 10'd2;
   assign crc_upd    = cfpr_pkg::crc_byte(running_crc_ff, rx_byte, crc_mode_ff);

   // Framing next state
   always_comb begin
      byte_position_in  = byte_position_ff;
      running_crc_in    = running_crc_ff;
      committed_bank_in = committed_bank_ff;
      have_frame_in     = have_frame_ff;
      status_in         = cfpr_pkg::ST_IGNORED;
      commit            = 1'b0;
      mem_wr_en         = 1'b0;
      if (req_tuser == cfpr_pkg::ACT_READ) begin
         status_in = cfpr_pkg::ST_IGNORED;
      end else if (byte_position_ff == '0) begin
         if (rx_byte == cfpr_pkg::START_MARK) begin
            running_crc_in   = cfpr_pkg::CRC_SEED;
            byte_position_in = POS_W'(1);
            status_in        = cfpr_pkg::ST_ACCEPTED;
         end
      end else if (byte_position_ff == POS_W'(1)) begin
         if (rx_byte == expected_len_ff) begin
            running_crc_in   = crc_upd;
            byte_position_in = POS_W'(2);
            status_in        = cfpr_pkg::ST_ACCEPTED;
         end else begin
            byte_position_in = '0;
            status_in        = cfpr_pkg::ST_REJECTED;
         end
      end else if (pos_ext < crc_lo_pos) begin
         mem_wr_en        = (pay_off < 10'(PAYLOAD_CAPACITY));
         running_crc_in   = crc_upd;
         byte_position_in = byte_position_ff + POS_W'(1);
         status_in        = cfpr_pkg::ST_ACCEPTED;
      end else if (pos_ext == crc_lo_pos) begin
         if (rx_byte == running_crc_ff[7:0]) begin
            byte_position_in = byte_position_ff + POS_W'(1);
            status_in        = cfpr_pkg::ST_ACCEPTED;
         end else begin
            byte_position_in = '0;
            status_in        = cfpr_pkg::ST_REJECTED;
         end
      end else begin
         // high CRC byte slot, or any position past it, closes the frame
         if (rx_byte == running_crc_ff[15:8]) begin
            commit            = 1'b1;
            committed_bank_in = !committed_bank_ff;
            have_frame_in     = 1'b1;
            status_in         = cfpr_pkg::ST_COMMITTED;
         end else begin
            status_in = cfpr_pkg::ST_REJECTED;
         end
         byte_position_in = '0;
      end
   end

   // Result side fields that do not come from the memory
   assign rd_en_in   = (req_tuser == cfpr_pkg::ACT_READ) && have_frame_ff &&
                       ({1'b0, read_index} < 9'(PAYLOAD_CAPACITY));
   assign crc_out_in = !have_frame_in ? 16'h0000 :
                       commit         ? running_crc_ff :
                                        bank_crc_ff[committed_bank_ff];

   // Memory addresses: write bank is the uncommitted one
   assign mem_wr_addr = MEM_AW'(32'(!committed_bank_ff) * PAYLOAD_CAPACITY + 32'(pay_off));
   assign mem_rd_addr = MEM_AW'(32'(committed_bank_ff) * PAYLOAD_CAPACITY + 32'(read_index));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_len_ff <= cfpr_pkg::LENGTH_RESET;
         crc_mode_ff     <= cfpr_pkg::CRC_MSB_FIRST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cfpr_pkg::CSR_EXPECTED_LEN: expected_len_ff <= csr_data;
            cfpr_pkg::CSR_CRC_MODE:     crc_mode_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         running_crc_ff    <= cfpr_pkg::CRC_SEED;
         committed_bank_ff <= 1'b0;
         have_frame_ff     <= 1'b0;
      end else if (in_acc) begin
         byte_position_ff  <= byte_position_in;
         running_crc_ff    <= running_crc_in;
         committed_bank_ff <= committed_bank_in;
         have_frame_ff     <= have_frame_in;
      end
   end

   // Per-bank CRC, no reset
   always_ff @(posedge clock) begin
      if (in_acc && commit) begin
         bank_crc_ff[!committed_bank_ff] <= running_crc_ff;
      end
   end

   // Payload memory: at most one write and one registered read per accepted transaction
   always_ff @(posedge clock) begin
      if (in_acc && mem_wr_en) begin
         payload_mem[mem_wr_addr] <= rx_byte;
      end
      if (in_acc) begin
         mem_q_ff <= payload_mem[mem_rd_addr];
      end
   end

   // Read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         s1_status_ff <= status_in;
         s1_crc_ff    <= crc_out_in;
         s1_avail_ff  <= have_frame_in;
         s1_rd_en_ff  <= rd_en_in;
      end
   end

   // Output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_data_ff <= {5'b00000, s1_avail_ff, s1_crc_ff,
                         (s1_rd_en_ff ? mem_q_ff : 8'h00), s1_status_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: sv/cfpr_checker.sv
// Port-level checker for the framed packet receiver, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfpr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cfpr_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0]  rsp_status;
   logic        rsp_avail;
   logic        rsp_stall;
   logic        rsp_commit;
   logic [23:0] rsp_body;

   assign rsp_status = rsp_tdata[1:0];
   assign rsp_avail  = rsp_tdata[26];
   assign rsp_body   = rsp_tdata[25:2];
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_commit = rsp_tvalid && (rsp_status == cfpr_pkg::ST_COMMITTED);

   // Output is empty right after reset
   `ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, reset |=> !rsp_tvalid)

   // A stalled response holds its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_tvalid && $stable(rsp_tdata)))

   // A commit always reports an available frame
   `ASSERT_CLK(a_commit_avail, clock, reset, rsp_commit |-> rsp_avail)

   // Without a frame, read byte and CRC are zero
   `ASSERT_CLK(a_no_frame_zero, clock, reset, (rsp_tvalid && !rsp_avail) |-> (rsp_body == '0))

endmodule

bind crc_framed_packet_receiver cfpr_checker u_cfpr_checker (.*);
